FILE: hdl/rsb_pkg.sv
// Package for the resequencing buffer: sizes, status and function codes, item types.
// No dependencies.
package rsb_pkg;
	localparam int DEPTH = 16;
	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int KEY_BITS = 32;
	localparam int FRAME_BITS = 64;
	localparam int TIME_BITS = 32;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_FETCH = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_TOO_OLD = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_FRAME_OUT = 3'd4;
	localparam logic [2:0] ST_NOT_READY = 3'd5;
	localparam logic [2:0] ST_TICK_DONE = 3'd6;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] in_key;
		logic [63:0] in_frame;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] out_key;
		logic [63:0] out_frame;
		logic out_forced;
	} out_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [FRAME_BITS-1:0] frame;
		logic [TIME_BITS-1:0] stamp;
	} entry_t;
endpackage

FILE: hdl/resequencing_buffer_with_timeout.sv
// Top level of the resequencing buffer: entry memory, scan sequencer, output register.
// Depends on rsb_pkg.
//
// channel | direction | handshake         | payload
// in      | in        | in_valid/in_ready | rsb_pkg::in_item_t
// out     | out       | out_valid/out_ready | rsb_pkg::out_item_t
// cfg     | in        | cfg_we            | cfg_data
//
// Tick passes through S_OUT. Insert and fetch scan the entry table, one memory read a cycle;
// a fetch that releases an entry adds a read of that entry in S_REL.
// Reset clears valid bits, time, expected key; memory contents need no clearing.
// A new item is taken once the previous result has left the output register.
module resequencing_buffer_with_timeout (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rsb_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output rsb_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [31:0] cfg_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_LAST = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_REL = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	rsb_pkg::entry_t mem [rsb_pkg::DEPTH];
	rsb_pkg::entry_t rd_q;
	logic [rsb_pkg::DEPTH-1:0] valid_q;
	logic [31:0] timeout_q;
	logic [rsb_pkg::TIME_BITS-1:0] now_q;
	logic [rsb_pkg::KEY_BITS-1:0] exp_q;
	logic known_q;
	logic [2:0] state_q;
	rsb_pkg::in_item_t cur_q;
	logic [rsb_pkg::IDX_BITS:0] addr_q;
	logic [rsb_pkg::IDX_BITS-1:0] rdi_q;
	logic dup_q;
	logic free_found_q;
	logic [rsb_pkg::IDX_BITS-1:0] free_q;
	logic best_found_q;
	logic [rsb_pkg::IDX_BITS-1:0] best_q;
	logic [rsb_pkg::KEY_BITS-1:0] best_key_q;
	logic [rsb_pkg::TIME_BITS-1:0] oldest_q;
	logic forced_q;
	rsb_pkg::out_item_t res_q;
	logic res_valid_q;

	logic we;
	logic [rsb_pkg::IDX_BITS-1:0] wa;
	logic [rsb_pkg::IDX_BITS-1:0] ra;
	logic [rsb_pkg::TIME_BITS-1:0] age;
	logic rv;

	assign in_ready = (state_q == S_IDLE) && !res_valid_q;
	assign out_valid = res_valid_q;
	assign out_item = res_q;
	assign rv = valid_q[rdi_q];
	assign age = now_q - rd_q.stamp;
	assign we = (state_q == S_DECIDE) && (cur_q.func == rsb_pkg::FUNC_INSERT) &&
		!(known_q && cur_q.in_key < exp_q) && !dup_q && free_found_q;
	assign wa = free_q;
	assign ra = (state_q == S_DECIDE) ? best_q :
		(state_q == S_IDLE) ? '0 : addr_q[rsb_pkg::IDX_BITS-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= '{key: cur_q.in_key, frame: cur_q.in_frame, stamp: now_q};
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			timeout_q <= rsb_pkg::TIMEOUT_RESET;
			now_q <= '0;
			exp_q <= '0;
			known_q <= 1'b0;
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			cur_q <= '0;
			addr_q <= '0;
			rdi_q <= '0;
			dup_q <= 1'b0;
			free_found_q <= 1'b0;
			free_q <= '0;
			best_found_q <= 1'b0;
			best_q <= '0;
			best_key_q <= '0;
			oldest_q <= '0;
			forced_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cur_q <= in_item;
						addr_q <= '0;
						dup_q <= 1'b0;
						free_found_q <= 1'b0;
						best_found_q <= 1'b0;
						oldest_q <= '0;
						case (in_item.func)
							rsb_pkg::FUNC_TICK: begin
								now_q <= now_q + 1'b1;
								state_q <= S_OUT;
							end
							rsb_pkg::FUNC_INSERT, rsb_pkg::FUNC_FETCH: begin
								addr_q <= (rsb_pkg::IDX_BITS+1)'(1);
								rdi_q <= '0;
								state_q <= S_SCAN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN, S_LAST: begin
					if (rv) begin
						if (rd_q.key == cur_q.in_key) dup_q <= 1'b1;
						if (!best_found_q || rd_q.key < best_key_q) begin
							best_found_q <= 1'b1;
							best_q <= rdi_q;
							best_key_q <= rd_q.key;
						end
						if (age > oldest_q) oldest_q <= age;
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= rdi_q;
					end
					rdi_q <= addr_q[rsb_pkg::IDX_BITS-1:0];
					addr_q <= addr_q + 1'b1;
					if (state_q == S_LAST) begin
						state_q <= S_DECIDE;
					end else if (addr_q == (rsb_pkg::IDX_BITS+1)'(rsb_pkg::DEPTH - 1)) begin
						state_q <= S_LAST;
					end
				end
				S_DECIDE: begin
					if (cur_q.func == rsb_pkg::FUNC_INSERT) begin
						if (known_q && cur_q.in_key < exp_q) res_q.status <= rsb_pkg::ST_TOO_OLD;
						else if (dup_q) res_q.status <= rsb_pkg::ST_DUPLICATE;
						else if (!free_found_q) res_q.status <= rsb_pkg::ST_FULL;
						else begin
							res_q.status <= rsb_pkg::ST_INSERTED;
							valid_q[wa] <= 1'b1;
						end
						res_q.out_key <= '0;
						res_q.out_frame <= '0;
						res_q.out_forced <= 1'b0;
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (best_found_q && ((known_q && best_key_q == exp_q) ||
						oldest_q >= timeout_q)) begin
						forced_q <= !(known_q && best_key_q == exp_q);
						state_q <= S_REL;
					end else begin
						res_q <= '{status: rsb_pkg::ST_NOT_READY, out_key: '0,
							out_frame: '0, out_forced: 1'b0};
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_REL: begin
					res_q <= '{status: rsb_pkg::ST_FRAME_OUT, out_key: rd_q.key,
						out_frame: rd_q.frame, out_forced: forced_q};
					res_valid_q <= 1'b1;
					valid_q[best_q] <= 1'b0;
					exp_q <= rd_q.key + 1'b1;
					known_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_OUT: begin
					res_q <= '{status: rsb_pkg::ST_TICK_DONE, out_key: '0,
						out_frame: '0, out_forced: 1'b0};
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/rsb_checker.sv
// Port-level checks for the resequencing buffer, bound to the top level.
// Depends on rsb_pkg.
module rsb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rsb_pkg::out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= rsb_pkg::ST_TICK_DONE)
		else $error("bad status");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != rsb_pkg::ST_FRAME_OUT |->
		out_item.out_key == '0 && out_item.out_frame == '0 && !out_item.out_forced)
		else $error("non-release item carries data");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("item taken while a result waits");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input item withdrawn before acceptance");
endmodule

bind resequencing_buffer_with_timeout rsb_checker u_rsb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
